@@ hdl/ping_reply_frame_rewriter_core_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the ping reply frame rewriter
// Concurrent checks sampled on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PING_REPLY_FRAME_REWRITER_CORE_MACROS_SVH
`define PING_REPLY_FRAME_REWRITER_CORE_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define PRFR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define PRFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/prfr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prfr_pkg
// Types, frame offsets and the address swap map of the ping reply rewriter.
// ----------------------------------------------------------------------------
package prfr_pkg;

  localparam int HEADER_BYTES = 34;
  localparam int POS_W        = 6;
  localparam int ADDR_W       = $clog2(HEADER_BYTES);
  localparam int ACC_W        = 20;

  localparam logic [POS_W-1:0] IP_START   = POS_W'(14);
  localparam logic [POS_W-1:0] CSUM_HI    = POS_W'(24);
  localparam logic [POS_W-1:0] CSUM_LO    = POS_W'(25);
  localparam logic [POS_W-1:0] LAST_HDR   = POS_W'(HEADER_BYTES - 1);
  localparam logic [POS_W-1:0] TYPE_POS   = POS_W'(HEADER_BYTES);
  localparam logic [POS_W-1:0] AFTER_TYPE = POS_W'(HEADER_BYTES + 1);

  typedef enum logic {
    SEL_MEM,
    SEL_LIT
  } sel_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  // Source entry for each reply header position: MAC pair and IP pair swap.
  function automatic logic [ADDR_W-1:0] swapped_index(input logic [ADDR_W-1:0] i);
    logic [ADDR_W-1:0] r;
    if (i < ADDR_W'(6)) begin
      r = i + ADDR_W'(6);
    end else if (i < ADDR_W'(12)) begin
      r = i - ADDR_W'(6);
    end else if (i >= ADDR_W'(26) && i < ADDR_W'(30)) begin
      r = i + ADDR_W'(4);
    end else if (i >= ADDR_W'(30) && i < ADDR_W'(34)) begin
      r = i - ADDR_W'(4);
    end else begin
      r = i;
    end
    return r;
  endfunction

endpackage

@@ hdl/prfr_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prfr_in_if / prfr_out_if
// Valid/ready byte channels into and out of the ping reply rewriter.
// ----------------------------------------------------------------------------
interface prfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface prfr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

@@ hdl/prfr_hdr_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prfr_hdr_mem
// Header byte store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module prfr_hdr_mem (
  input  logic               clk,
  input  prfr_pkg::mem_req_t req,
  output logic [7:0]         rd_data
);

  logic [7:0] mem [prfr_pkg::HEADER_BYTES];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Hold read data until the next read.
  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data_r <= mem[req.raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hdl/ping_reply_frame_rewriter_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ping_reply_frame_rewriter_core
// Turns an Ethernet/IPv4 echo frame, one byte per beat, into its reply frame.
// ----------------------------------------------------------------------------
// Path: a pass-through beat is registered in the read stage, then in the output
//   register; header beats take the same path once byte 33 (or a short-frame end) is in.
// Throughput: 1 beat per cycle unless the output stalls; after the header's last
//   byte (or a frame that ends early) input stalls while the header store is read
//   out, one entry per cycle through its single read port: 34 entries, or pos+1 when short.
// Reset: rst_n (synchronous, low) clears position, checksum and mode; the
//   header store is not cleared, only entries written in a frame are read.
// ----------------------------------------------------------------------------
`include "ping_reply_frame_rewriter_core_macros.svh"

module ping_reply_frame_rewriter_core (
  input  logic              clk,
  input  logic              rst_n,
  prfr_in_if.sink           in_ch,
  prfr_out_if.source        out_ch
);

  localparam int POS_W  = prfr_pkg::POS_W;
  localparam int ADDR_W = prfr_pkg::ADDR_W;
  localparam int ACC_W  = prfr_pkg::ACC_W;

  // Frame tracking
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic              pass_r, pass_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;

  // Checksum fold, free running off the accumulator
  logic [16:0]       fold_r;
  logic [15:0]       csum_r;

  // Header readout sequencer
  logic              flush_active_r, flush_active_nxt;
  logic [POS_W-1:0]  flush_cnt_r, flush_cnt_nxt;
  logic [POS_W-1:0]  flush_end_r, flush_end_nxt;
  logic              flush_swap_r, flush_swap_nxt;
  logic              flush_last_r, flush_last_nxt;

  // Read stage (aligned with registered memory data)
  logic              s1_vld_r, s1_vld_nxt;
  prfr_pkg::sel_t    s1_sel_r, s1_sel_nxt;
  logic [7:0]        s1_lit_r, s1_lit_nxt;
  logic              s1_last_r, s1_last_nxt;

  // Output register
  logic              out_vld_r, out_vld_nxt;
  logic [7:0]        out_byte_r, out_byte_nxt;
  logic              out_last_r, out_last_nxt;

  logic              in_fire;
  logic              s1_move;
  logic              s1_free;
  logic              flush_issue;
  logic              flush_done;
  logic [7:0]        rd_data;
  logic [15:0]       csum_word;
  prfr_pkg::mem_req_t mem_req;

  assign s1_move     = s1_vld_r && (!out_vld_r || out_ch.ready);
  assign s1_free     = !s1_vld_r || s1_move;
  assign flush_issue = flush_active_r && s1_free;
  assign flush_done  = flush_issue && (flush_cnt_r == flush_end_r);

  // Hold input while the header is read out or the read stage cannot move on.
  assign in_ch.ready = !flush_active_r && s1_free;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Byte weight within its 16-bit word: even offsets are the high byte.
  assign csum_word = pos_r[0] ? {8'h00, in_ch.in_byte} : {in_ch.in_byte, 8'h00};

  // Write header bytes; read the swapped or plain entry during readout.
  always_comb begin
    mem_req.we    = in_fire && !pass_r;
    mem_req.waddr = pos_r[ADDR_W-1:0];
    mem_req.wdata = in_ch.in_byte;
    mem_req.re    = flush_issue;
    mem_req.raddr = flush_swap_r ? prfr_pkg::swapped_index(flush_cnt_r[ADDR_W-1:0])
                                 : flush_cnt_r[ADDR_W-1:0];
  end

  prfr_hdr_mem u_hdr_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  always_comb begin
    pos_nxt          = pos_r;
    pass_nxt         = pass_r;
    acc_nxt          = acc_r;
    flush_active_nxt = flush_active_r;
    flush_cnt_nxt    = flush_cnt_r;
    flush_end_nxt    = flush_end_r;
    flush_swap_nxt   = flush_swap_r;
    flush_last_nxt   = flush_last_r;
    s1_vld_nxt       = s1_vld_r;
    s1_sel_nxt       = s1_sel_r;
    s1_lit_nxt       = s1_lit_r;
    s1_last_nxt      = s1_last_r;
    out_vld_nxt      = out_vld_r;
    out_byte_nxt     = out_byte_r;
    out_last_nxt     = out_last_r;

    // Advance the output register.
    if (s1_move) begin
      out_vld_nxt  = 1'b1;
      out_byte_nxt = (s1_sel_r == prfr_pkg::SEL_MEM) ? rd_data : s1_lit_r;
      out_last_nxt = s1_last_r;
    end else if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end

    if (s1_move) begin
      s1_vld_nxt = 1'b0;
    end

    // Header readout: in a full-header readout the checksum field comes from the folded sum.
    if (flush_issue) begin
      s1_vld_nxt  = 1'b1;
      s1_last_nxt = flush_done && flush_last_r;
      if (flush_swap_r && flush_cnt_r == prfr_pkg::CSUM_HI) begin
        s1_sel_nxt = prfr_pkg::SEL_LIT;
        s1_lit_nxt = csum_r[15:8];
      end else if (flush_swap_r && flush_cnt_r == prfr_pkg::CSUM_LO) begin
        s1_sel_nxt = prfr_pkg::SEL_LIT;
        s1_lit_nxt = csum_r[7:0];
      end else begin
        s1_sel_nxt = prfr_pkg::SEL_MEM;
      end
      flush_cnt_nxt = flush_cnt_r + POS_W'(1);
      if (flush_done) begin
        flush_active_nxt = 1'b0;
        acc_nxt          = '0;
      end
    end

    if (in_fire) begin
      if (pass_r) begin
        // Pass the beat on; zero the ICMP type.
        s1_vld_nxt  = 1'b1;
        s1_sel_nxt  = prfr_pkg::SEL_LIT;
        s1_lit_nxt  = (pos_r == prfr_pkg::TYPE_POS) ? 8'h00 : in_ch.in_byte;
        s1_last_nxt = in_ch.in_last;
        if (in_ch.in_last) begin
          pos_nxt  = '0;
          pass_nxt = 1'b0;
        end else if (pos_r < prfr_pkg::AFTER_TYPE) begin
          pos_nxt = pos_r + POS_W'(1);
        end
      end else begin
        if (pos_r >= prfr_pkg::IP_START && pos_r != prfr_pkg::CSUM_HI &&
            pos_r != prfr_pkg::CSUM_LO) begin
          acc_nxt = acc_r + {{(ACC_W-16){1'b0}}, csum_word};
        end
        if (pos_r == prfr_pkg::LAST_HDR) begin
          // Full header: read it out rewritten.
          flush_active_nxt = 1'b1;
          flush_cnt_nxt    = '0;
          flush_end_nxt    = pos_r;
          flush_swap_nxt   = 1'b1;
          flush_last_nxt   = in_ch.in_last;
          if (in_ch.in_last) begin
            pos_nxt = '0;
          end else begin
            pass_nxt = 1'b1;
            pos_nxt  = prfr_pkg::TYPE_POS;
          end
        end else if (in_ch.in_last) begin
          // Short frame: read back what was held, unchanged.
          flush_active_nxt = 1'b1;
          flush_cnt_nxt    = '0;
          flush_end_nxt    = pos_r;
          flush_swap_nxt   = 1'b0;
          flush_last_nxt   = 1'b1;
          pos_nxt          = '0;
        end else begin
          pos_nxt = pos_r + POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r          <= '0;
      pass_r         <= 1'b0;
      acc_r          <= '0;
      flush_active_r <= 1'b0;
      flush_cnt_r    <= '0;
      flush_end_r    <= '0;
      flush_swap_r   <= 1'b0;
      flush_last_r   <= 1'b0;
      s1_vld_r       <= 1'b0;
      out_vld_r      <= 1'b0;
    end else begin
      pos_r          <= pos_nxt;
      pass_r         <= pass_nxt;
      acc_r          <= acc_nxt;
      flush_active_r <= flush_active_nxt;
      flush_cnt_r    <= flush_cnt_nxt;
      flush_end_r    <= flush_end_nxt;
      flush_swap_r   <= flush_swap_nxt;
      flush_last_r   <= flush_last_nxt;
      s1_vld_r       <= s1_vld_nxt;
      out_vld_r      <= out_vld_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    s1_sel_r   <= s1_sel_nxt;
    s1_lit_r   <= s1_lit_nxt;
    s1_last_r  <= s1_last_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  // Fold carries twice and complement, through fold_r and then csum_r; the result
  // settles long before the checksum field is read out.
  always_ff @(posedge clk) begin
    fold_r <= {1'b0, acc_r[15:0]} + {13'b0, acc_r[ACC_W-1:16]};
    csum_r <= ~(fold_r[15:0] + {15'b0, fold_r[16]});
  end

  assign out_ch.valid    = out_vld_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.out_last = out_last_r;

  `PRFR_ASSERT_NOW(a_no_write_in_flush, mem_req.we, !flush_active_r,
    "header store written during readout")
  `PRFR_ASSERT_NOW(a_flush_in_range, flush_active_r, flush_cnt_r <= flush_end_r,
    "readout counter ran past the held header")
  `PRFR_ASSERT_NEXT(a_flush_stops, flush_done, !flush_active_r && acc_r == '0,
    "readout did not stop or checksum not cleared")
  `PRFR_ASSERT_NOW(a_pass_pos, pass_r, pos_r >= prfr_pkg::TYPE_POS,
    "pass-through mode with position inside the header")

endmodule

@@ tb/tb_ping_reply_frame_rewriter_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ping_reply_frame_rewriter_core
// Streams echo frames, short frames and noise through the rewriter. Reply
// beats are checked against the predictor's copy of the rewrite, which swaps
// the addresses and recomputes the IP checksum, or against typed-in replies for
// hand-checked rows. The sender and the receiver idle and stall at random.
// ----------------------------------------------------------------------------
module tb_ping_reply_frame_rewriter_core;

  localparam int CLK_HALF      = 4;
  localparam int RESET_CYCLES  = 9;
  localparam int RANDOM_BYTES  = 230;
  localparam int HOLD_CYCLES   = 150;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 200000;

  // One beat of the reply frame as the receiver should see it.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } reply_beat_t;

  // One beat offered to the block. Rows with hand_checked set carry their own
  // reply beat, typed in; all other rows are checked against the predictor.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       hand_checked;
    logic [7:0] reply_data;
    logic       reply_last;
  } frame_row_t;

  typedef enum int {
    FR_ECHO,
    FR_NOISE,
    FR_FLAT
  } frame_kind_t;

  typedef enum int {
    RX_OPEN,
    RX_COIN,
    RX_PATTERN,
    RX_SPARSE
  } rx_mode_t;

  // Directed frames. All of them end before the header is complete, so each
  // byte comes back unchanged once the frame's last byte has gone in.
  localparam frame_row_t DIRECTED [21] = '{
    '{8'h00, 1'b1, 1'b1, 8'h00, 1'b1},
    '{8'hFF, 1'b1, 1'b1, 8'hFF, 1'b1},
    '{8'hAA, 1'b0, 1'b1, 8'hAA, 1'b0},
    '{8'h55, 1'b1, 1'b1, 8'h55, 1'b1},
    '{8'h01, 1'b0, 1'b1, 8'h01, 1'b0},
    '{8'h80, 1'b0, 1'b1, 8'h80, 1'b0},
    '{8'h7F, 1'b1, 1'b1, 8'h7F, 1'b1},
    // broadcast destination, stops right after the ethertype
    '{8'hFF, 1'b0, 1'b1, 8'hFF, 1'b0},
    '{8'hFF, 1'b0, 1'b1, 8'hFF, 1'b0},
    '{8'hFF, 1'b0, 1'b1, 8'hFF, 1'b0},
    '{8'hFF, 1'b0, 1'b1, 8'hFF, 1'b0},
    '{8'hFF, 1'b0, 1'b1, 8'hFF, 1'b0},
    '{8'hFF, 1'b0, 1'b1, 8'hFF, 1'b0},
    '{8'h00, 1'b0, 1'b1, 8'h00, 1'b0},
    '{8'h12, 1'b0, 1'b1, 8'h12, 1'b0},
    '{8'h34, 1'b0, 1'b1, 8'h34, 1'b0},
    '{8'h56, 1'b0, 1'b1, 8'h56, 1'b0},
    '{8'h78, 1'b0, 1'b1, 8'h78, 1'b0},
    '{8'h9A, 1'b0, 1'b1, 8'h9A, 1'b0},
    '{8'h08, 1'b0, 1'b1, 8'h08, 1'b0},
    '{8'h00, 1'b1, 1'b1, 8'h00, 1'b1}
  };

  logic clk;
  logic rst_n;

  prfr_in_if  in_ch ();
  prfr_out_if out_ch ();

  ping_reply_frame_rewriter_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Reply beats still owed by the block, oldest first.
  reply_beat_t reply_q [$];
  int          errors = 0;
  longint      cycles = 0;

  // Predictor state: a private copy of the header and the frame progress.
  logic [7:0]                 hdr_copy [prfr_pkg::HEADER_BYTES];
  logic [prfr_pkg::POS_W-1:0] frame_pos = '0;
  logic [prfr_pkg::ACC_W-1:0] hdr_sum   = '0;
  logic                       in_payload = 1'b0;

  // Sender/receiver coordination.
  frame_row_t drv_row;
  int         burst_left = 0;
  bit         steady     = 1'b0;
  int         hold_reqs  = 0;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Advance the predictor by one accepted input beat. With mute set the state
  // still advances but nothing is queued: the row brought its own reply.
  task automatic predict_reply(input logic [7:0] b, input logic l, input bit mute);
    logic [prfr_pkg::POS_W-1:0] p;
    logic [prfr_pkg::ACC_W-1:0] folded;
    logic [15:0]                csum;
    logic [7:0]                 v;
    int                         src;
    p = frame_pos;
    if (in_payload) begin
      // Past the header: zero the ICMP type, pass everything else.
      v = (p == prfr_pkg::TYPE_POS) ? 8'h00 : b;
      if (!mute) reply_q.push_back('{data: v, last: l});
      if (l) begin
        frame_pos  = '0;
        hdr_sum    = '0;
        in_payload = 1'b0;
      end else if (p < prfr_pkg::AFTER_TYPE) begin
        frame_pos = p + 1'b1;
      end
    end else begin
      if (p > prfr_pkg::LAST_HDR) p = prfr_pkg::LAST_HDR;
      hdr_copy[p] = b;
      // The IP header starts on an even offset: odd positions hold low bytes.
      if (p >= prfr_pkg::IP_START && p != prfr_pkg::CSUM_HI && p != prfr_pkg::CSUM_LO) begin
        hdr_sum = hdr_sum + (p[0] ? {12'h000, b} : {4'h0, b, 8'h00});
      end
      if (p == prfr_pkg::LAST_HDR) begin
        // Fold the carries twice, then complement.
        folded = {4'h0, hdr_sum[15:0]} + {16'h0000, hdr_sum[19:16]};
        folded = {4'h0, folded[15:0]} + {16'h0000, folded[19:16]};
        csum   = ~folded[15:0];
        for (int i = 0; i < prfr_pkg::HEADER_BYTES; i++) begin
          // Destination and source MAC trade places, and so do the IP addresses.
          if (i < 6)                 src = i + 6;
          else if (i < 12)           src = i - 6;
          else if (i >= 26 && i < 30) src = i + 4;
          else if (i >= 30)          src = i - 4;
          else                       src = i;
          if (i == int'(prfr_pkg::CSUM_HI))      v = csum[15:8];
          else if (i == int'(prfr_pkg::CSUM_LO)) v = csum[7:0];
          else                                   v = hdr_copy[src];
          if (!mute) begin
            reply_q.push_back('{data: v,
                                last: (i == prfr_pkg::HEADER_BYTES - 1) ? l : 1'b0});
          end
        end
        if (l) begin
          frame_pos = '0;
          hdr_sum   = '0;
        end else begin
          in_payload = 1'b1;
          frame_pos  = prfr_pkg::TYPE_POS;
        end
      end else if (l) begin
        // Short frame: flush what was held, unchanged.
        for (int i = 0; i <= int'(p); i++) begin
          if (!mute) reply_q.push_back('{data: hdr_copy[i], last: (i == int'(p))});
        end
        frame_pos = '0;
        hdr_sum   = '0;
      end else begin
        frame_pos = p + 1'b1;
      end
    end
  endtask

  // Check the reply beat first, then account for the input beat taken at the
  // same edge: the block cannot answer a beat in the cycle it takes it.
  always @(posedge clk) begin
    reply_beat_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (reply_q.size() == 0) begin
          $error("unexpected beat: out_byte=%02h out_last=%0b", out_ch.out_byte,
                 out_ch.out_last);
          errors++;
        end else begin
          want = reply_q.pop_front();
          if (out_ch.out_byte !== want.data) begin
            $error("out_byte: expected %02h, got %02h", want.data, out_ch.out_byte);
            errors++;
          end
          if (out_ch.out_last !== want.last) begin
            $error("out_last: expected %0b, got %0b", want.last, out_ch.out_last);
            errors++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (drv_row.hand_checked) begin
          reply_q.push_back('{data: drv_row.reply_data, last: drv_row.reply_last});
        end
        predict_reply(in_ch.in_byte, in_ch.in_last, drv_row.hand_checked);
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_ping_reply_frame_rewriter_core NOT OK");
      $finish;
    end
  end

  // Receiver: switch between stall patterns now and then, at random. A hold
  // request drops ready for a long stretch so the block backs up into its input.
  initial begin : receiver
    int       hold_left;
    int       hold_seen;
    int       mode_left;
    logic [1:0] phase;
    rx_mode_t mode;
    hold_left    = 0;
    hold_seen    = 0;
    mode_left    = 0;
    phase        = '0;
    mode         = RX_OPEN;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 80);
        end
        mode_left--;
        phase++;
        case (mode)
          RX_OPEN:    out_ch.ready <= 1'b1;
          RX_COIN:    out_ch.ready <= 1'($urandom_range(0, 1));
          RX_PATTERN: out_ch.ready <= (phase != 2'b11);
          default:    out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Offer one beat and hold it until the block takes it. Bursts of random
  // length are separated by idle gaps, except in steady stretches.
  task automatic offer_beat(input frame_row_t row);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = steady ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    drv_row = row;
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= row.data;
    in_ch.in_last <= row.last;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
  endtask

  // Drop valid and wait for every owed reply beat.
  task automatic pause_until_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (reply_q.size() != 0) @(posedge clk);
  endtask

  // Send one frame. Echo frames carry a plausible IPv4/ICMP header with random
  // addresses and fields; the old checksum bytes are random and must be ignored.
  task automatic send_frame(input frame_kind_t kind, input int len, input logic [7:0] fill);
    frame_row_t row;
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom);
      case (kind)
        FR_ECHO: begin
          case (i)
            12:      b = 8'h08;
            13:      b = 8'h00;
            14:      b = 8'h45;
            23:      b = 8'h01;
            34:      b = 8'h08;
            default: ;
          endcase
        end
        FR_FLAT: b = fill;
        default: ;
      endcase
      row = '{data: b, last: (i == len - 1), hand_checked: 1'b0,
              reply_data: 8'h00, reply_last: 1'b0};
      offer_beat(row);
    end
  endtask

  initial begin : stimulus
    int          sent;
    int          pick;
    int          len;
    frame_kind_t kind;
    logic [7:0]  fill;
    sent          = 0;
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = 8'h00;
    in_ch.in_last = 1'b0;
    drv_row       = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i]) offer_beat(DIRECTED[i]);

    // Frame shapes at the header boundary first: ends on the last header byte,
    // ends on the type byte, ends one byte short, checksum at both extremes.
    send_frame(FR_ECHO, 34, 8'h00);
    send_frame(FR_ECHO, 35, 8'h00);
    // Hold off the receiver while a full header streams in behind it.
    hold_reqs++;
    send_frame(FR_FLAT, 34, 8'hFF);
    send_frame(FR_ECHO, 33, 8'h00);
    pause_until_drained();
    send_frame(FR_FLAT, 35, 8'h00);
    send_frame(FR_ECHO, 36, 8'h00);
    send_frame(FR_NOISE, 1, 8'h00);
    sent = 34 + 35 + 34 + 33 + 35 + 36 + 1;

    // Mostly well-formed echo frames; the rest short frames, noise and flat
    // headers with random fill.
    while (sent < RANDOM_BYTES) begin
      steady = ($urandom_range(0, 3) == 0);
      pick   = $urandom_range(0, 99);
      fill   = 8'($urandom);
      if (pick < 60) begin
        kind = FR_ECHO;
        len  = $urandom_range(34, 48);
      end else if (pick < 75) begin
        kind = FR_ECHO;
        len  = $urandom_range(1, 33);
      end else if (pick < 90) begin
        kind = FR_NOISE;
        len  = $urandom_range(1, 50);
      end else begin
        kind = FR_FLAT;
        len  = $urandom_range(30, 40);
      end
      send_frame(kind, len, fill);
      sent += len;
      if ($urandom_range(0, 9) == 0) pause_until_drained();
    end

    pause_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && reply_q.size() == 0) begin
      $display("tb_ping_reply_frame_rewriter_core OK");
    end else begin
      $display("tb_ping_reply_frame_rewriter_core NOT OK");
    end
    $finish;
  end

endmodule
